// ===== rtl/core/qrm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quaternion to rotation matrix block.
// Field widths, fixed-point formats, pipeline depths and the result record.
// No dependencies.

package qrm_pkg;

	localparam int FRAC_BITS = 14;

	localparam int IN_W  = 16;
	localparam int OUT_W = 16;
	localparam int SCL_W = 16;

	localparam int PRD_W = 2 * IN_W;
	localparam int SQ_W  = 2 * IN_W - 1;
	localparam int NRM_W = 2 * IN_W + 1;
	localparam int SUM_W = 2 * IN_W;
	localparam int CRS_W = 2 * IN_W + 1;
	localparam int PS_W  = SCL_W + SUM_W;
	localparam int PO_W  = SCL_W + CRS_W;

	localparam int NUM_W = ((NRM_W + FRAC_BITS > PS_W) ? NRM_W + FRAC_BITS : PS_W) + 1;
	localparam int QUO_W = OUT_W;
	localparam int DIV_W = (NUM_W > NRM_W + QUO_W) ? NUM_W : NRM_W + QUO_W;
	localparam int DIV_LAT = QUO_W + 3;

	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	typedef logic signed [OUT_W-1:0] ent_t;
	typedef logic [PADDR_W-3:0] reg_idx_t;

	localparam reg_idx_t REG_SCALE = reg_idx_t'(0);
	localparam logic [SCL_W-1:0] SCALE_RST = SCL_W'(32768);

	localparam ent_t SAT_MAX = ent_t'({1'b0, {(OUT_W-1){1'b1}}});
	localparam ent_t SAT_MIN = ent_t'({1'b1, {(OUT_W-1){1'b0}}});
	localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};
	localparam ent_t ONE_SAT = (FRAC_BITS >= OUT_W - 1) ? SAT_MAX : ent_t'(1 << FRAC_BITS);

	typedef struct packed {
		ent_t m00;
		ent_t m01;
		ent_t m02;
		ent_t m10;
		ent_t m11;
		ent_t m12;
		ent_t m20;
		ent_t m21;
		ent_t m22;
		logic zero_norm;
	} mat_t;

	localparam mat_t IDENT = '{
		m00: ONE_SAT, m01: '0, m02: '0,
		m10: '0, m11: ONE_SAT, m12: '0,
		m20: '0, m21: '0, m22: ONE_SAT,
		zero_norm: 1'b1
	};

	function automatic logic signed [PRD_W-1:0] smul(input logic signed [IN_W-1:0] a,
			input logic signed [IN_W-1:0] b);
		return PRD_W'(a) * PRD_W'(b);
	endfunction

endpackage

// ===== rtl/core/qrm_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: quaternion beats in, matrix beats out.
// Depends on qrm_pkg.

interface qrm_quat_if
	import qrm_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [IN_W-1:0] qx;
	logic signed [IN_W-1:0] qy;
	logic signed [IN_W-1:0] qz;
	logic signed [IN_W-1:0] qw;

	modport source(output valid, output qx, output qy, output qz, output qw, input ready);
	modport sink(input valid, input qx, input qy, input qz, input qw, output ready);
endinterface

interface qrm_mat_if
	import qrm_pkg::*;
;
	logic valid;
	logic ready;
	ent_t m00;
	ent_t m01;
	ent_t m02;
	ent_t m10;
	ent_t m11;
	ent_t m12;
	ent_t m20;
	ent_t m21;
	ent_t m22;
	logic zero_norm;

	modport source(output valid, output m00, output m01, output m02, output m10, output m11,
		output m12, output m20, output m21, output m22, output zero_norm, input ready);
	modport sink(input valid, input m00, input m01, input m02, input m10, input m11,
		input m12, input m20, input m21, input m22, input zero_norm, output ready);
endinterface

// ===== rtl/core/quaternion_to_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix, top level: APB scale register,
// product/sum/scale stages, nine qrm_div lanes, output skid. Depends on qrm_pkg, qrm_if.

// Takes one quaternion beat per cycle and returns its nine matrix entries
// (row-major, signed Q2.14, saturated) through four stages of products, sums,
// scaling and numerator forming, then 19 stages in each divider lane (16 of
// them one quotient bit each of the restoring division by the norm squared),
// then the output register. Sustained rate is one beat per cycle. A stall on
// the matrix side is absorbed by a one-beat skid; quat.ready drops only while
// that skid is full, and the whole pipe holds. An all-zero quaternion returns
// the identity with zero_norm set. scale_factor sits at byte address 0 (reset
// 2.0); the user must write it only while idle, the block doesn't enforce it.

module quaternion_to_rotation_matrix_top
	import qrm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	qrm_quat_if.sink           quat,
	qrm_mat_if.source          mat
);

	logic             en;
	logic [SCL_W-1:0] scale_q;
	reg_idx_t         reg_idx;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [SQ_W-1:0]         sq_c [4];
	logic signed [PRD_W-1:0] pr_c [6];
	logic [SQ_W-1:0]         sq_s1 [4];
	logic signed [PRD_W-1:0] pr_s1 [6];

	logic [NRM_W-1:0]        n_s2;
	logic [SUM_W-1:0]        sum_s2 [3];
	logic signed [CRS_W-1:0] crs_s2 [6];

	logic [NRM_W-1:0]        n_s3;
	logic                    zero_s3;
	logic [PS_W-1:0]         ps_s3 [3];
	logic signed [PO_W-1:0]  po_s3 [6];
	logic signed [PO_W-1:0]  scl_c;

	logic signed [NUM_W-1:0] dg_c [3];
	logic [NRM_W-1:0]        n_s4;
	logic                    zero_s4;
	logic signed [NUM_W-1:0] num_s4 [9];

	logic vld_sd [DIV_LAT];
	logic zro_sd [DIV_LAT];
	ent_t res [9];

	mat_t last_c;
	mat_t out_q;
	mat_t skid_q;
	logic out_v_q;
	logic skid_v_q;

	// config port
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_SCALE) ? APB_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (psel && penable && pwrite && reg_idx == REG_SCALE) begin
			scale_q <= pwdata[SCL_W-1:0];
		end
	end

	assign en         = !skid_v_q;
	assign quat.ready = en;

	always_comb begin
		sq_c[0] = SQ_W'(smul(quat.qx, quat.qx));
		sq_c[1] = SQ_W'(smul(quat.qy, quat.qy));
		sq_c[2] = SQ_W'(smul(quat.qz, quat.qz));
		sq_c[3] = SQ_W'(smul(quat.qw, quat.qw));
		pr_c[0] = smul(quat.qx, quat.qy);
		pr_c[1] = smul(quat.qx, quat.qz);
		pr_c[2] = smul(quat.qx, quat.qw);
		pr_c[3] = smul(quat.qy, quat.qz);
		pr_c[4] = smul(quat.qy, quat.qw);
		pr_c[5] = smul(quat.qz, quat.qw);
		scl_c   = PO_W'($signed({1'b0, scale_q}));
		for (int d = 0; d < 3; d++) begin
			dg_c[d] = $signed((NUM_W'(n_s3) << FRAC_BITS) - NUM_W'(ps_s3[d]));
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1      <= quat.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			vld_sd[0] <= v_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= sq_c;
			pr_s1 <= pr_c;

			n_s2      <= NRM_W'(sq_s1[0]) + NRM_W'(sq_s1[1]) + NRM_W'(sq_s1[2])
				+ NRM_W'(sq_s1[3]);
			sum_s2[0] <= SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
			sum_s2[1] <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[2]);
			sum_s2[2] <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]);
			crs_s2[0] <= CRS_W'(pr_s1[0]) - CRS_W'(pr_s1[5]);
			crs_s2[1] <= CRS_W'(pr_s1[1]) + CRS_W'(pr_s1[4]);
			crs_s2[2] <= CRS_W'(pr_s1[0]) + CRS_W'(pr_s1[5]);
			crs_s2[3] <= CRS_W'(pr_s1[3]) - CRS_W'(pr_s1[2]);
			crs_s2[4] <= CRS_W'(pr_s1[1]) - CRS_W'(pr_s1[4]);
			crs_s2[5] <= CRS_W'(pr_s1[3]) + CRS_W'(pr_s1[2]);

			n_s3    <= n_s2;
			zero_s3 <= n_s2 == '0;
			for (int d = 0; d < 3; d++) begin
				ps_s3[d] <= PS_W'(scale_q) * PS_W'(sum_s2[d]);
			end
			for (int k = 0; k < 6; k++) begin
				po_s3[k] <= scl_c * PO_W'(crs_s2[k]);
			end

			n_s4      <= n_s3;
			zero_s4   <= zero_s3;
			num_s4[0] <= dg_c[0];
			num_s4[1] <= NUM_W'(po_s3[0]);
			num_s4[2] <= NUM_W'(po_s3[1]);
			num_s4[3] <= NUM_W'(po_s3[2]);
			num_s4[4] <= dg_c[1];
			num_s4[5] <= NUM_W'(po_s3[3]);
			num_s4[6] <= NUM_W'(po_s3[4]);
			num_s4[7] <= NUM_W'(po_s3[5]);
			num_s4[8] <= dg_c[2];

			zro_sd[0] <= zero_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				zro_sd[k] <= zro_sd[k-1];
			end
		end
	end

	for (genvar i = 0; i < 9; i++) begin : g_lane
		qrm_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s4[i]),
			.den (n_s4),
			.res (res[i])
		);
	end

	always_comb begin
		if (zro_sd[DIV_LAT-1]) begin
			last_c = IDENT;
		end else begin
			last_c.m00       = res[0];
			last_c.m01       = res[1];
			last_c.m02       = res[2];
			last_c.m10       = res[3];
			last_c.m11       = res[4];
			last_c.m12       = res[5];
			last_c.m20       = res[6];
			last_c.m21       = res[7];
			last_c.m22       = res[8];
			last_c.zero_norm = 1'b0;
		end
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (vld_sd[DIV_LAT-1]) begin
				if (!out_v_q || mat.ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (mat.ready) begin
				out_v_q <= 1'b0;
			end
		end else if (mat.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vld_sd[DIV_LAT-1]) begin
				if (!out_v_q || mat.ready) begin
					out_q <= last_c;
				end else begin
					skid_q <= last_c;
				end
			end
		end else if (mat.ready) begin
			out_q <= skid_q;
		end
	end

	assign mat.valid     = out_v_q;
	assign mat.m00       = out_q.m00;
	assign mat.m01       = out_q.m01;
	assign mat.m02       = out_q.m02;
	assign mat.m10       = out_q.m10;
	assign mat.m11       = out_q.m11;
	assign mat.m12       = out_q.m12;
	assign mat.m20       = out_q.m20;
	assign mat.m21       = out_q.m21;
	assign mat.m22       = out_q.m22;
	assign mat.zero_norm = out_q.zero_norm;

endmodule

// ===== rtl/core/qrm_div.sv =====
`timescale 1ns / 1ps
// One matrix entry: rounded signed ratio num / den, pipelined restoring
// division one quotient bit per stage, saturated to 16 bits. Depends on qrm_pkg.

module qrm_div
	import qrm_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic [NRM_W-1:0]        den,
	output ent_t                    res
);

	logic [DIV_W-1:0] d_c;
	logic [DIV_W-1:0] d_s1;
	logic [NRM_W-1:0] n_s1;
	logic             neg_s1;

	logic [DIV_W-1:0] rem_s [QUO_W];
	logic [NRM_W-1:0] n_s [QUO_W];
	logic [QUO_W-1:0] q_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];
	logic             neg_s [QUO_W+1];

	logic [DIV_W-1:0] dv_c [QUO_W];
	logic             ge_c [QUO_W];
	ent_t             sat_c;
	ent_t             res_q;

	always_comb begin
		// |num| plus half the divisor: round to nearest, ties away from zero
		if (num[NUM_W-1]) begin
			d_c = DIV_W'(den >> 1) - DIV_W'(num);
		end else begin
			d_c = DIV_W'(num) + DIV_W'(den >> 1);
		end
		for (int k = 0; k < QUO_W; k++) begin
			dv_c[k] = DIV_W'(n_s[k]) << (QUO_W - 1 - k);
			ge_c[k] = rem_s[k] >= dv_c[k];
		end
		if (neg_s[QUO_W]) begin
			if (ovf_s[QUO_W] || q_s[QUO_W] > NEG_LIM) begin
				sat_c = SAT_MIN;
			end else begin
				sat_c = ent_t'(-q_s[QUO_W]);
			end
		end else begin
			if (ovf_s[QUO_W] || q_s[QUO_W][QUO_W-1]) begin
				sat_c = SAT_MAX;
			end else begin
				sat_c = ent_t'(q_s[QUO_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_c;
			n_s1   <= den;
			neg_s1 <= num[NUM_W-1];

			rem_s[0] <= d_s1;
			n_s[0]   <= n_s1;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= d_s1 >= (DIV_W'(n_s1) << QUO_W);
			q_s[0]   <= '0;

			for (int k = 0; k < QUO_W; k++) begin
				q_s[k+1]   <= {q_s[k][QUO_W-2:0], ge_c[k]};
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
			end
			for (int k = 1; k < QUO_W; k++) begin
				rem_s[k] <= ge_c[k-1] ? rem_s[k-1] - dv_c[k-1] : rem_s[k-1];
				n_s[k]   <= n_s[k-1];
			end

			res_q <= sat_c;
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/qrm_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the quaternion to rotation matrix top, and the bind
// that attaches them. Depends on qrm_pkg and quaternion_to_rotation_matrix_top.

module qrm_chk
	import qrm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mat_t out_mat
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mat))
		else $error("output beat changed while stalled");

	// input side only backs up after an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("ready low without output stall");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready && out_valid)
		else $error("skid drained without output beat taken");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mat.zero_norm |->
			out_mat.m00 == ONE_SAT && out_mat.m11 == ONE_SAT && out_mat.m22 == ONE_SAT
			&& out_mat.m01 == '0 && out_mat.m02 == '0 && out_mat.m10 == '0
			&& out_mat.m12 == '0 && out_mat.m20 == '0 && out_mat.m21 == '0)
		else $error("zero norm beat is not the identity");

endmodule

bind quaternion_to_rotation_matrix_top qrm_chk u_qrm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (quat.ready),
	.out_valid (mat.valid),
	.out_ready (mat.ready),
	.out_mat   ({mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
		mat.m20, mat.m21, mat.m22, mat.zero_norm})
);

// ===== test/qrm_matrix_checker.sv =====
`timescale 1ns / 1ps
// Matrix checker: follows scale register writes, predicts the rotation matrix of
// each accepted quaternion beat and compares every matrix beat in order.
// Depends on qrm_pkg and the channel interfaces in qrm_if.

module qrm_matrix_checker
	import qrm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	qrm_quat_if                quat,
	qrm_mat_if                 mat,
	output int                 outstanding,
	output int                 mismatches
);

	logic [SCL_W-1:0] scale;
	mat_t matrices_due[$];
	mat_t want;

	// nearest, ties away from zero; den > 0
	function automatic longint round_ratio(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic ent_t clamp(input longint v);
		if (v > 32767)
			return ent_t'(32767);
		if (v < -32768)
			return ent_t'(-32768);
		return ent_t'(v);
	endfunction

	function automatic mat_t rotation_matrix_of(input logic signed [IN_W-1:0] qx,
			input logic signed [IN_W-1:0] qy, input logic signed [IN_W-1:0] qz,
			input logic signed [IN_W-1:0] qw, input logic [SCL_W-1:0] scl);
		longint x, y, z, w, n, s, unit, on;
		mat_t m;
		x = qx;
		y = qy;
		z = qz;
		w = qw;
		s = longint'(scl);
		unit = longint'(1) << FRAC_BITS;
		n = x * x + y * y + z * z + w * w;
		m = '0;
		if (n == 0) begin
			m.m00 = clamp(unit);
			m.m11 = clamp(unit);
			m.m22 = clamp(unit);
			m.zero_norm = 1'b1;
			return m;
		end
		on = unit * n;
		m.m00 = clamp(round_ratio(on - s * (y * y + z * z), n));
		m.m01 = clamp(round_ratio(s * (x * y - z * w), n));
		m.m02 = clamp(round_ratio(s * (x * z + y * w), n));
		m.m10 = clamp(round_ratio(s * (x * y + z * w), n));
		m.m11 = clamp(round_ratio(on - s * (x * x + z * z), n));
		m.m12 = clamp(round_ratio(s * (y * z - x * w), n));
		m.m20 = clamp(round_ratio(s * (x * z - y * w), n));
		m.m21 = clamp(round_ratio(s * (y * z + x * w), n));
		m.m22 = clamp(round_ratio(on - s * (x * x + y * y), n));
		return m;
	endfunction

	task automatic compare_entry(input string name, input ent_t exp_v, input ent_t got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale <= SCALE_RST;
			matrices_due.delete();
			outstanding <= 0;
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_SCALE)
				scale <= pwdata[SCL_W-1:0];
			if (quat.valid && quat.ready)
				matrices_due.push_back(rotation_matrix_of(quat.qx, quat.qy, quat.qz,
					quat.qw, scale));
			if (mat.valid && mat.ready) begin
				if (matrices_due.size() == 0) begin
					$error("matrix beat with no quaternion outstanding");
					mismatches++;
				end else begin
					want = matrices_due.pop_front();
					compare_entry("m00", want.m00, mat.m00);
					compare_entry("m01", want.m01, mat.m01);
					compare_entry("m02", want.m02, mat.m02);
					compare_entry("m10", want.m10, mat.m10);
					compare_entry("m11", want.m11, mat.m11);
					compare_entry("m12", want.m12, mat.m12);
					compare_entry("m20", want.m20, mat.m20);
					compare_entry("m21", want.m21, mat.m21);
					compare_entry("m22", want.m22, mat.m22);
					if (want.zero_norm !== mat.zero_norm) begin
						$error("zero_norm mismatch: expected %0b, got %0b",
							want.zero_norm, mat.zero_norm);
						mismatches++;
					end
				end
			end
			outstanding <= matrices_due.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for quaternion_to_rotation_matrix_top: clock, reset, APB scale
// writes and quaternion/matrix beats with random gaps. Depends on qrm_pkg, qrm_if,
// qrm_matrix_checker and the block itself.

module tb;
	import qrm_pkg::*;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
		logic signed [IN_W-1:0] w;
	} quat_t;

	localparam int STALL_MAX = 13;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PER_SETTING = 250;
	localparam logic [PADDR_W-1:0] SCALE_ADDR = {REG_SCALE, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = {reg_idx_t'(REG_SCALE + 1), 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;

	int mismatches;
	int outstanding;
	int readback_errors = 0;
	int quats_sent = 0;
	int idle_cycles = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;

	qrm_quat_if quat_ch ();
	qrm_mat_if mat_ch ();

	quaternion_to_rotation_matrix_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.quat(quat_ch),
		.mat(mat_ch)
	);

	qrm_matrix_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.quat(quat_ch),
		.mat(mat_ch),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	always #5 clk = ~clk;

	function automatic quat_t mk(input int x, input int y, input int z, input int w);
		return '{IN_W'(x), IN_W'(y), IN_W'(z), IN_W'(w)};
	endfunction

	function automatic quat_t random_quat();
		quat_t q;
		real a, b, c, d, len, target;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			a = real'($urandom_range(0, 65534)) - 32767.0;
			b = real'($urandom_range(0, 65534)) - 32767.0;
			c = real'($urandom_range(0, 65534)) - 32767.0;
			d = real'($urandom_range(0, 65534)) - 32767.0;
			len = $sqrt(a * a + b * b + c * c + d * d);
			target = ($urandom_range(0, 9) == 0) ? real'($urandom_range(2000, 32000)) : 16384.0;
			if (len < 1.0)
				return mk(0, 0, 0, 16384);
			q = mk($rtoi(a / len * target), $rtoi(b / len * target),
				$rtoi(c / len * target), $rtoi(d / len * target));
		end else if (pick < 80) begin
			q = quat_t'({$urandom, $urandom});
		end else if (pick < 95) begin
			q = mk(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
				int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3);
		end else begin
			q = '0;
		end
		return q;
	endfunction

	task automatic send_quat(input quat_t q);
		int gap;
		if ($urandom_range(0, 99) < 2)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			quat_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		quat_ch.valid <= 1'b1;
		quat_ch.qx <= q.x;
		quat_ch.qy <= q.y;
		quat_ch.qz <= q.z;
		quat_ch.qw <= q.w;
		@(posedge clk);
		while (!quat_ch.ready) @(posedge clk);
		quats_sent++;
	endtask

	task automatic settle();
		quat_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_scale_readback(input logic [SCL_W-1:0] exp_v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= SCALE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[SCL_W-1:0] !== exp_v) begin
			$error("scale_factor readback mismatch: expected %0d, got %0d", exp_v,
				prdata[SCL_W-1:0]);
			readback_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int gap;
		mat_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < 2)
				sink_calm = !sink_calm;
			gap = sink_calm ? 0 : $urandom_range(0, STALL_MAX);
			if (gap > 0) begin
				mat_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			mat_ch.ready <= 1'b1;
			@(posedge clk);
			while (!mat_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (quat_ch.valid && quat_ch.ready) || (mat_ch.valid && mat_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		quat_t corner[$];
		logic [SCL_W-1:0] settings[$];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		quat_ch.valid <= 1'b0;
		quat_ch.qx <= '0;
		quat_ch.qy <= '0;
		quat_ch.qz <= '0;
		quat_ch.qw <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_scale_readback(SCALE_RST);

		// corners at the reset scale of 2.0
		corner.push_back(mk(0, 0, 0, 0));
		corner.push_back(mk(0, 0, 0, 16384));
		corner.push_back(mk(0, 0, 0, -16384));
		corner.push_back(mk(16384, 0, 0, 0));
		corner.push_back(mk(0, 16384, 0, 0));
		corner.push_back(mk(0, 0, 16384, 0));
		corner.push_back(mk(-16384, 0, 0, 0));
		corner.push_back(mk(11585, 0, 0, 11585));
		corner.push_back(mk(0, 11585, 0, 11585));
		corner.push_back(mk(0, 0, 11585, -11585));
		corner.push_back(mk(8192, 8192, 8192, 8192));
		corner.push_back(mk(32767, 32767, 32767, 32767));
		corner.push_back(mk(-32768, -32768, -32768, -32768));
		corner.push_back(mk(32767, -32768, 32767, -32768));
		corner.push_back(mk(-32768, 0, 0, 0));
		corner.push_back(mk(1, 0, 0, 0));
		corner.push_back(mk(0, 0, 0, 1));
		corner.push_back(mk(1, 1, 1, 1));
		corner.push_back(mk(1, -1, 0, 0));
		corner.push_back(mk(32767, 0, 0, 1));
		corner.push_back(mk(-1, -1, -1, -1));
		corner.push_back(mk(0, 32767, -32768, 0));
		corner.push_back(mk(-32768, 32767, 0, 0));
		foreach (corner[i])
			send_quat(corner[i]);
		repeat (RANDOM_PER_SETTING) send_quat(random_quat());

		settings = '{16'd0, 16'hFFFF, 16'd16384, 16'd1, 16'($urandom), SCALE_RST};
		foreach (settings[i]) begin
			settle();
			apb_write(SCALE_ADDR, {16'($urandom), settings[i]});
			apb_write(SPARE_ADDR, $urandom);
			check_scale_readback(settings[i]);
			send_quat(mk(0, 0, 0, 0));
			send_quat(mk(32767, -32768, 1, -1));
			repeat (RANDOM_PER_SETTING) send_quat(random_quat());
		end
		settle();
		repeat (40) @(posedge clk);

		$display("Sent %0d quaternions over %0d scale settings: corners, zero,", quats_sent,
			settings.size() + 1);
		$display("near-unit, full-range and tiny-norm inputs with random gaps and stalls.");
		if (mismatches + readback_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
